### src/sprq_pkg.sv
// shared types and codes for the stable priority ready queue
`default_nettype none
package sprq_pkg;

   // result status codes
   localparam int STATUS_BITS = 2;
   typedef logic [STATUS_BITS-1:0] status_code_type;
   localparam status_code_type STATUS_OK        = 2'd0;
   localparam status_code_type STATUS_EMPTY_POP = 2'd1;
   localparam status_code_type STATUS_FULL_INS  = 2'd2;

   // request command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // controller states
   typedef enum logic {
      CTL_IDLE,
      CTL_HOLD
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic            accept;   // request transfer this cycle
      logic            write;    // queue contents change
      logic            pop;      // shift toward the head instead of insert
      status_code_type code;     // status of the result being captured
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

endpackage
`default_nettype wire

### src/stable_priority_ready_queue_unit.sv
// top level of the stable sorted priority ready queue
`default_nettype none
// A ready queue of up to QUEUE_DEPTH entries (priority plus process tag),
// held as a row of slot registers sorted highest priority first. An insert
// lands behind every stored entry of equal or greater priority, so equal
// priorities leave in arrival order; a pop returns the head. Every request
// transfer gives exactly one response, valid from the next cycle and held
// until its transfer, carrying a
// status (ok, pop on empty, insert on full), the popped entry (zero for
// inserts and failed pops) and the occupancy after the command. All slots
// compare against the new priority in parallel and shift in the same edge,
// and a new request is taken while the previous response is being taken,
// so one command per cycle is sustained; a stalled response holds the
// request side off. Slot contents are not cleared at reset; only slots
// below the fill count are ever read.
module stable_priority_ready_queue_unit #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 3,
   parameter int PAYLOAD_BITS  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [PRIORITY_BITS-1:0]          req_priority_req,
   input  wire logic [PAYLOAD_BITS-1:0]           req_payload,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output sprq_pkg::status_code_type              rsp_status,
   output logic [PRIORITY_BITS-1:0]               rsp_out_priority,
   output logic [PAYLOAD_BITS-1:0]                rsp_out_payload,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_occupancy
);
   import sprq_pkg::*;

   // command from the state machine, fullness back from the slots
   dp_cmd_type    cmd;
   dp_status_type dp_status;

   sprq_controller u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .rsp_stall   (rsp_stall),
      .dp_status   (dp_status),
      .cmd         (cmd),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid)
   );

   sprq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .dp_status        (dp_status),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_occupancy    (rsp_occupancy)
   );

   // every request transfer shows a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no response after request transfer");

   // occupancy never passes the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("occupancy beyond queue depth");

   // a pop on an empty queue returns zeros and an empty queue
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY_POP) |->
         (rsp_out_priority == '0 && rsp_out_payload == '0 && rsp_occupancy == '0))
      else $error("empty pop result not clean");

   // a full-queue insert reports a full queue
   a_full_ins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL_INS) |->
         (rsp_occupancy == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
      else $error("full insert with room left");

endmodule
`default_nettype wire

### src/sprq_datapath.sv
// sorted slot array, fill count and result register
`default_nettype none
module sprq_datapath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 3,
   parameter int PAYLOAD_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sprq_pkg::dp_cmd_type               cmd,
   input  wire logic [PRIORITY_BITS-1:0]           req_priority_req,
   input  wire logic [PAYLOAD_BITS-1:0]            req_payload,
   output sprq_pkg::dp_status_type                 dp_status,
   output sprq_pkg::status_code_type               rsp_status,
   output logic [PRIORITY_BITS-1:0]                rsp_out_priority,
   output logic [PAYLOAD_BITS-1:0]                 rsp_out_payload,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        rsp_occupancy
);
   import sprq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0]            fill_ff, fill_in;
   logic [PRIORITY_BITS-1:0] prio_ff [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] prio_in [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0]  tag_ff  [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0]  tag_in  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   behind;

   status_code_type          status_ff;
   logic [PRIORITY_BITS-1:0] out_prio_ff, out_prio_in;
   logic [PAYLOAD_BITS-1:0]  out_tag_ff, out_tag_in;
   logic [CW-1:0]            occ_ff;

   // behind[i]: slot i is empty or holds a strictly lower priority
   // (a thermometer, since slots are kept sorted)
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      assign behind[i] = (CW'(i) >= fill_ff) || (prio_ff[i] < req_priority_req);

      always_comb begin
         prio_in[i] = prio_ff[i];
         tag_in[i]  = tag_ff[i];
         if (cmd.pop) begin
            if (i < QUEUE_DEPTH - 1) begin
               prio_in[i] = prio_ff[(i + 1) % QUEUE_DEPTH];
               tag_in[i]  = tag_ff[(i + 1) % QUEUE_DEPTH];
            end
         end else if (behind[i]) begin
            if (i > 0 && behind[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
               prio_in[i] = prio_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
               tag_in[i]  = tag_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
            end else begin
               prio_in[i] = req_priority_req;
               tag_in[i]  = req_payload;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.write) begin
            prio_ff[i] <= prio_in[i];
            tag_ff[i]  <= tag_in[i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.write) begin
         fill_in = cmd.pop ? fill_ff - CW'(1) : fill_ff + CW'(1);
      end
      out_prio_in = '0;
      out_tag_in  = '0;
      if (cmd.write && cmd.pop) begin
         out_prio_in = prio_ff[0];
         out_tag_in  = tag_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff   <= cmd.code;
         out_prio_ff <= out_prio_in;
         out_tag_ff  <= out_tag_in;
         occ_ff      <= fill_in;
      end
   end

   assign dp_status.empty = (fill_ff == '0);
   assign dp_status.full  = (fill_ff == CW'(QUEUE_DEPTH));

   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_out_payload  = out_tag_ff;
   assign rsp_occupancy    = occ_ff;

endmodule
`default_nettype wire

### src/sprq_controller.sv
// handshake and command decode state machine
`default_nettype none
module sprq_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_command,
   input  wire logic                    rsp_stall,
   input  wire sprq_pkg::dp_status_type dp_status,
   output sprq_pkg::dp_cmd_type         cmd,
   output logic                         req_stall,
   output logic                         rsp_valid
);
   import sprq_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          accept;

   assign req_stall = (state_ff == CTL_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) state_in = CTL_HOLD;
         end
         CTL_HOLD: begin
            if (!rsp_stall && !req_valid) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd.accept = accept;
      cmd.pop    = (req_command == CMD_POP);
      cmd.write  = 1'b0;
      cmd.code   = STATUS_OK;
      if (req_command == CMD_POP) begin
         if (dp_status.empty) cmd.code = STATUS_EMPTY_POP;
         else                 cmd.write = accept;
      end else begin
         if (dp_status.full) cmd.code = STATUS_FULL_INS;
         else                cmd.write = accept;
      end
      unique case (state_ff)
         CTL_IDLE: rsp_valid = 1'b0;
         CTL_HOLD: rsp_valid = 1'b1;
         default:  rsp_valid = 1'b0;
      endcase
   end

endmodule
`default_nettype wire
